// File: rtl/tgpr_pkg.sv
`timescale 1ns / 1ps
// tgpr_pkg: shared constants and types for the TDOA grid-point residual unit.
// No dependencies.
package tgpr_pkg;

    localparam int REG_W     = 48;  // packed position / difference registers
    localparam int LIMIT_W   = 16;  // acceptance limit, unsigned Q8.8
    localparam int POINT_W   = 16;  // input coordinate fields
    localparam int RESID_W   = 16;  // residual output field
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPK_A       = 3'd0,
        REG_SPK_B       = 3'd1,
        REG_SPK_C       = 3'd2,
        REG_SPK_D       = 3'd3,
        REG_MEAS_FIRST  = 3'd4,
        REG_MEAS_SECOND = 3'd5,
        REG_LIMIT       = 3'd6
    } reg_idx_t;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd256;  // 1.0 in Q8.8

    localparam int NUM_SPK   = 4;
    localparam int NUM_AXES  = 3;
    localparam int NUM_PAIRS = 6;

    // Pair order AB, BC, AC, AD, BD, CD: first minus second.
    localparam int PAIR_FIRST  [NUM_PAIRS] = '{0, 1, 0, 0, 1, 2};
    localparam int PAIR_SECOND [NUM_PAIRS] = '{1, 2, 2, 3, 3, 3};

    // Error magnitude clamp and the widths that follow from it.
    localparam int ERR_MAG_W = 17;
    localparam logic [ERR_MAG_W-1:0] ERR_CLAMP = 17'h10000;
    localparam int ERR_SQ_W   = 2 * ERR_MAG_W;     // 34
    localparam int SSE_W      = ERR_SQ_W + 4;      // six terms, kept even
    localparam int RES_ROOT_W = SSE_W / 2;         // 19

    localparam logic [RESID_W-1:0] RESID_MAX = 16'hFFFF;

endpackage

// File: rtl/tgpr_point_if.sv
`timescale 1ns / 1ps
// tgpr_point_if: candidate point channel (valid/ready plus x, y, z).
// Depends on tgpr_pkg.
interface tgpr_point_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [tgpr_pkg::POINT_W-1:0]  point_x;
    logic signed [tgpr_pkg::POINT_W-1:0]  point_y;
    logic signed [tgpr_pkg::POINT_W-1:0]  point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// File: rtl/tgpr_result_if.sv
`timescale 1ns / 1ps
// tgpr_result_if: residual result channel (valid/ready plus residual, accepted).
// Depends on tgpr_pkg.
interface tgpr_result_if;
    logic                               valid;
    logic                               ready;
    logic [tgpr_pkg::RESID_W-1:0]       residual;
    logic                               accepted;

    modport source (output valid, output residual, output accepted, input ready);
    modport sink   (input valid, input residual, input accepted, output ready);
endinterface

// File: rtl/tgpr_dist_sq.sv
`timescale 1ns / 1ps
// tgpr_dist_sq: per-speaker squared Euclidean distance, three register stages.
// Depends on tgpr_pkg.
module tgpr_dist_sq #(
    parameter int CB = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic signed [CB-1:0] point [tgpr_pkg::NUM_AXES],
    input  logic signed [CB-1:0] spk   [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES],
    output logic                out_valid,
    output logic [2*((CB > 31) ? 31 : CB)+1:0] out_sum [tgpr_pkg::NUM_SPK]
);
    localparam int MAG_W = (CB > 31) ? 31 : CB;
    localparam int SQ_W  = 2 * MAG_W + 2;
    localparam logic [CB-1:0] MAG_MAX = CB'((64'd1 << MAG_W) - 64'd1);

    logic signed [CB:0]     diff  [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];
    logic [CB-1:0]          mag   [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];
    logic [MAG_W-1:0]       mag_c [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];

    logic [MAG_W-1:0]       mag_reg [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];
    logic [2*MAG_W-1:0]     sq_reg  [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];
    logic [SQ_W-1:0]        sum_reg [tgpr_pkg::NUM_SPK];
    logic                   v1_reg, v2_reg, v3_reg;

    for (genvar l = 0; l < tgpr_pkg::NUM_SPK; l++) begin : g_lane
        for (genvar a = 0; a < tgpr_pkg::NUM_AXES; a++) begin : g_axis
            assign diff[l][a]  = (CB+1)'(point[a]) - (CB+1)'(spk[l][a]);
            assign mag[l][a]   = diff[l][a][CB] ? CB'(-diff[l][a]) : CB'(diff[l][a]);
            // only bites at coordinates wider than 31 bits
            assign mag_c[l][a] = (mag[l][a] > MAG_MAX) ? {MAG_W{1'b1}}
                                                       : MAG_W'(mag[l][a]);
        end
        assign out_sum[l] = sum_reg[l];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < tgpr_pkg::NUM_SPK; l++)
            begin
                for (int a = 0; a < tgpr_pkg::NUM_AXES; a++)
                begin
                    mag_reg[l][a] <= mag_c[l][a];
                    sq_reg[l][a]  <= mag_reg[l][a] * mag_reg[l][a];
                end
                sum_reg[l] <= SQ_W'(sq_reg[l][0]) + SQ_W'(sq_reg[l][1])
                            + SQ_W'(sq_reg[l][2]);
            end
        end
    end

    assign out_valid = v3_reg;
endmodule

// File: rtl/tgpr_isqrt.sv
`timescale 1ns / 1ps
// tgpr_isqrt: pipelined floor square root, one result bit per stage, several lanes.
// Depends on nothing beyond the language.
module tgpr_isqrt #(
    parameter int W     = 32,
    parameter int LANES = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [W-1:0]     in_rad  [LANES],
    output logic             out_valid,
    output logic [W/2-1:0]   out_root [LANES]
);
    localparam int N = W / 2;

    logic [N-1:0]   v_reg;
    logic [W-1:0]   rad_reg  [N][LANES];
    logic [N+2:0]   rem_reg  [N][LANES];
    logic [N-1:0]   root_reg [N][LANES];

    logic           src_v    [N];
    logic [W-1:0]   src_rad  [N][LANES];
    logic [N+2:0]   src_rem  [N][LANES];
    logic [N-1:0]   src_root [N][LANES];

    logic [W-1:0]   nxt_rad  [N][LANES];
    logic [N+2:0]   nxt_rem  [N][LANES];
    logic [N-1:0]   nxt_root [N][LANES];

    for (genvar s = 0; s < N; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign src_v[s] = in_valid;
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign src_rad[s][l]  = in_rad[l];
                assign src_rem[s][l]  = '0;
                assign src_root[s][l] = '0;
            end
        end
        else begin : g_rest
            assign src_v[s] = v_reg[s-1];
            for (genvar l = 0; l < LANES; l++) begin : g_lane
                assign src_rad[s][l]  = rad_reg[s-1][l];
                assign src_rem[s][l]  = rem_reg[s-1][l];
                assign src_root[s][l] = root_reg[s-1][l];
            end
        end

        for (genvar l = 0; l < LANES; l++) begin : g_step
            logic [N+2:0] cur;
            logic [N+2:0] trial;
            logic         ge;
            assign cur   = {src_rem[s][l][N:0], src_rad[s][l][W-1:W-2]};
            assign trial = {1'b0, src_root[s][l], 2'b01};
            assign ge    = (cur >= trial);
            assign nxt_rem[s][l]  = ge ? (cur - trial) : cur;
            assign nxt_root[s][l] = {src_root[s][l][N-2:0], ge};
            assign nxt_rad[s][l]  = {src_rad[s][l][W-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < N; s++)
            begin
                v_reg[s] <= src_v[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < N; s++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rad_reg[s][l]  <= nxt_rad[s][l];
                    rem_reg[s][l]  <= nxt_rem[s][l];
                    root_reg[s][l] <= nxt_root[s][l];
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    for (genvar l = 0; l < LANES; l++) begin : g_out
        assign out_root[l] = root_reg[N-1][l];
    end
endmodule

// File: rtl/tgpr_err.sv
`timescale 1ns / 1ps
// tgpr_err: six distance differences against measured values, squared and summed.
// Three register stages. Depends on tgpr_pkg.
module tgpr_err #(
    parameter int CB = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [((CB > 31) ? 31 : CB):0] spk_range [tgpr_pkg::NUM_SPK],
    input  logic signed [CB-1:0] meas [tgpr_pkg::NUM_PAIRS],
    output logic                 out_valid,
    output logic [tgpr_pkg::SSE_W-1:0] out_sse
);
    localparam int D_W = ((CB > 31) ? 31 : CB) + 1;
    localparam int EW  = ((CB > D_W + 1) ? CB : D_W + 1) + 1;
    localparam int MW  = (EW > tgpr_pkg::ERR_MAG_W) ? EW : tgpr_pkg::ERR_MAG_W;

    logic signed [D_W:0]     test [tgpr_pkg::NUM_PAIRS];
    logic signed [EW-1:0]    err  [tgpr_pkg::NUM_PAIRS];
    logic [EW-1:0]           mag  [tgpr_pkg::NUM_PAIRS];
    logic [MW-1:0]           mag_w[tgpr_pkg::NUM_PAIRS];

    logic [tgpr_pkg::ERR_MAG_W-1:0] mag_reg [tgpr_pkg::NUM_PAIRS];
    logic [tgpr_pkg::ERR_SQ_W-1:0]  sq_reg  [tgpr_pkg::NUM_PAIRS];
    logic [tgpr_pkg::SSE_W-1:0]     sse_reg;
    logic                           v1_reg, v2_reg, v3_reg;

    for (genvar p = 0; p < tgpr_pkg::NUM_PAIRS; p++) begin : g_pair
        assign test[p] = $signed({1'b0, spk_range[tgpr_pkg::PAIR_FIRST[p]]})
                       - $signed({1'b0, spk_range[tgpr_pkg::PAIR_SECOND[p]]});
        assign err[p]   = EW'(meas[p]) - EW'(test[p]);
        assign mag[p]   = err[p][EW-1] ? EW'(-err[p]) : EW'(err[p]);
        assign mag_w[p] = MW'(mag[p]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int p = 0; p < tgpr_pkg::NUM_PAIRS; p++)
            begin
                // a clamped error already forces saturation and rejection
                mag_reg[p] <= (mag_w[p] > MW'(tgpr_pkg::ERR_CLAMP))
                              ? tgpr_pkg::ERR_CLAMP
                              : tgpr_pkg::ERR_MAG_W'(mag_w[p]);
                sq_reg[p]  <= mag_reg[p] * mag_reg[p];
            end
            sse_reg <= tgpr_pkg::SSE_W'(sq_reg[0]) + tgpr_pkg::SSE_W'(sq_reg[1])
                     + tgpr_pkg::SSE_W'(sq_reg[2]) + tgpr_pkg::SSE_W'(sq_reg[3])
                     + tgpr_pkg::SSE_W'(sq_reg[4]) + tgpr_pkg::SSE_W'(sq_reg[5]);
        end
    end

    assign out_valid = v3_reg;
    assign out_sse   = sse_reg;
endmodule

// File: rtl/tdoa_grid_point_residual_unit.sv
`timescale 1ns / 1ps
// Pipeline from point word to result word, in order:
// 3 distance-square stages, one stage per distance root bit, 3 error stages,
// 19 residual root stages and the output register.
// Throughput: one word per cycle; the whole pipeline holds while a result waits.
// Reset: asynchronous, active low; clears valid bits and sets config to defaults
// (positions and differences 0, acceptance limit 1.0).
module tdoa_grid_point_residual_unit #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    tgpr_point_if.sink                          pt,
    tgpr_result_if.source                       res,
    input  logic                                cfg_we,
    input  logic [tgpr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tgpr_pkg::REG_W-1:0]          cfg_data
);
    localparam int CB    = COORD_BITS;
    localparam int MAG_W = (CB > 31) ? 31 : CB;
    localparam int SQ_W  = 2 * MAG_W + 2;
    localparam int D_W   = SQ_W / 2;

    // ---------------- configuration registers ----------------
    logic [tgpr_pkg::REG_W-1:0]   spk_pos_reg [tgpr_pkg::NUM_SPK];
    logic [tgpr_pkg::REG_W-1:0]   meas_first_reg;
    logic [tgpr_pkg::REG_W-1:0]   meas_second_reg;
    logic [tgpr_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tgpr_pkg::NUM_SPK; i++)
            begin
                spk_pos_reg[i] <= '0;
            end
            meas_first_reg  <= '0;
            meas_second_reg <= '0;
            limit_reg       <= tgpr_pkg::LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tgpr_pkg::REG_SPK_A:       spk_pos_reg[0]  <= cfg_data;
                tgpr_pkg::REG_SPK_B:       spk_pos_reg[1]  <= cfg_data;
                tgpr_pkg::REG_SPK_C:       spk_pos_reg[2]  <= cfg_data;
                tgpr_pkg::REG_SPK_D:       spk_pos_reg[3]  <= cfg_data;
                tgpr_pkg::REG_MEAS_FIRST:  meas_first_reg  <= cfg_data;
                tgpr_pkg::REG_MEAS_SECOND: meas_second_reg <= cfg_data;
                tgpr_pkg::REG_LIMIT:       limit_reg <= cfg_data[tgpr_pkg::LIMIT_W-1:0];
                default:                   ;  // unused index: write dropped
            endcase
        end
    end

    // Slot k of a packed register: bits past the register read as zero,
    // then the slot is taken as a signed COORD_BITS value.
    function automatic logic [CB-1:0] get_slot(input logic [tgpr_pkg::REG_W-1:0] r,
                                               input int k);
        logic [tgpr_pkg::REG_W+2*CB-1:0] ext;
        ext = {{(2*CB){1'b0}}, r};
        ext = ext >> (k * CB);
        return ext[CB-1:0];
    endfunction

    logic signed [CB-1:0] spk_c  [tgpr_pkg::NUM_SPK][tgpr_pkg::NUM_AXES];
    logic signed [CB-1:0] meas_c [tgpr_pkg::NUM_PAIRS];
    logic signed [CB-1:0] point_c[tgpr_pkg::NUM_AXES];

    for (genvar l = 0; l < tgpr_pkg::NUM_SPK; l++) begin : g_spk
        for (genvar a = 0; a < tgpr_pkg::NUM_AXES; a++) begin : g_axis
            assign spk_c[l][a] = $signed(get_slot(spk_pos_reg[l], a));
        end
    end
    for (genvar k = 0; k < tgpr_pkg::NUM_AXES; k++) begin : g_meas
        assign meas_c[k]     = $signed(get_slot(meas_first_reg, k));
        assign meas_c[k + 3] = $signed(get_slot(meas_second_reg, k));
    end

    // Input fields: low COORD_BITS bits, zero-extended if the field is narrower.
    logic [CB+tgpr_pkg::POINT_W-1:0] px_ext, py_ext, pz_ext;
    assign px_ext = {{CB{1'b0}}, pt.point_x};
    assign py_ext = {{CB{1'b0}}, pt.point_y};
    assign pz_ext = {{CB{1'b0}}, pt.point_z};
    assign point_c[0] = $signed(px_ext[CB-1:0]);
    assign point_c[1] = $signed(py_ext[CB-1:0]);
    assign point_c[2] = $signed(pz_ext[CB-1:0]);

    // ---------------- pipeline ----------------
    // Every stage moves together; the output register is the only holding point.
    logic adv;
    logic out_valid_reg;
    logic [tgpr_pkg::RESID_W-1:0] residual_reg;
    logic accepted_reg;

    assign adv      = !out_valid_reg || res.ready;
    assign pt.ready = adv;

    logic            dsq_valid;
    logic [SQ_W-1:0] dsq_sum [tgpr_pkg::NUM_SPK];

    tgpr_dist_sq #(.CB(CB)) u_dist_sq (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (pt.valid),
        .point    (point_c),
        .spk      (spk_c),
        .out_valid(dsq_valid),
        .out_sum  (dsq_sum)
    );

    logic           range_valid;
    logic [D_W-1:0] spk_range [tgpr_pkg::NUM_SPK];

    tgpr_isqrt #(.W(SQ_W), .LANES(tgpr_pkg::NUM_SPK)) u_dist_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (dsq_valid),
        .in_rad   (dsq_sum),
        .out_valid(range_valid),
        .out_root (spk_range)
    );

    logic                       sse_valid;
    logic [tgpr_pkg::SSE_W-1:0] sse;

    tgpr_err #(.CB(CB)) u_err (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (range_valid),
        .spk_range(spk_range),
        .meas     (meas_c),
        .out_valid(sse_valid),
        .out_sse  (sse)
    );

    logic                            root_valid;
    logic [tgpr_pkg::SSE_W-1:0]      sse_lane  [1];
    logic [tgpr_pkg::RES_ROOT_W-1:0] root_lane [1];

    assign sse_lane[0] = sse;

    tgpr_isqrt #(.W(tgpr_pkg::SSE_W), .LANES(1)) u_res_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (adv),
        .in_valid (sse_valid),
        .in_rad   (sse_lane),
        .out_valid(root_valid),
        .out_root (root_lane)
    );

    // Output register: saturate the residual, compare the unsaturated root.
    logic [tgpr_pkg::RESID_W-1:0] residual_next;
    logic                         accepted_next;

    assign residual_next = (root_lane[0] > tgpr_pkg::RES_ROOT_W'(tgpr_pkg::RESID_MAX))
                           ? tgpr_pkg::RESID_MAX
                           : root_lane[0][tgpr_pkg::RESID_W-1:0];
    assign accepted_next = (root_lane[0] <= tgpr_pkg::RES_ROOT_W'(limit_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= root_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            residual_reg <= residual_next;
            accepted_reg <= accepted_next;
        end
    end

    assign res.valid    = out_valid_reg;
    assign res.residual = residual_reg;
    assign res.accepted = accepted_reg;

    // ---------------- assertions ----------------
    a_hold_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(range_valid) && $stable(sse_valid) && $stable(root_valid))
        else $error("pipeline moved during a stall");

    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |=> out_valid_reg && $stable(residual_reg)
                                          && $stable(accepted_reg))
        else $error("pending result word lost or changed");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(root_valid))
        else $error("result word appeared without a pipeline word");
endmodule
